// File: design/mpa_pkg.sv
// shared types and constants for the max pooling block
package mpa_pkg;

  localparam int unsigned REG_KERNEL_WIDTH  = 0;
  localparam int unsigned REG_KERNEL_HEIGHT = 1;
  localparam int unsigned REG_STRIDE_X      = 2;
  localparam int unsigned REG_STRIDE_Y      = 3;
  localparam int unsigned REG_IMAGE_WIDTH   = 4;
  localparam int unsigned REG_IMAGE_HEIGHT  = 5;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 11;
  localparam int unsigned SMALL_BITS     = 4;
  localparam int unsigned ROW_BITS       = 10;

  localparam int unsigned MAX_STRIDE = 8;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam logic [3:0]  RESET_KERNEL = 4'd2;
  localparam logic [3:0]  RESET_STRIDE = 4'd2;
  localparam logic [10:0] RESET_IMAGE  = 11'd1024;

  typedef struct packed {
    logic write;  // store the accepted pixel and advance the counters
    logic step;   // issue one window read
    logic load;   // move the window result to the output register
  } cmd_t;

  typedef struct packed {
    logic fire;       // current pixel closes a window
    logic scan_last;  // read being issued is the last of the window
    logic out_free;   // output register can take a result
  } status_t;

endpackage

// File: design/mpa_ram.sv
// generic simple dual port ram with registered read
module mpa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/mpa_datapath.sv
// counters, line store, window scan and output register
module mpa_datapath import mpa_pkg::*; #(
  parameter int unsigned MAX_KERNEL  = 8,
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [SAMPLE_BITS-1:0]    pixel_value,
  input  cmd_t                      cmd,
  output status_t                   status,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [SAMPLE_BITS-1:0]    max_value,
  output logic [SMALL_BITS-1:0]     max_row,
  output logic [SMALL_BITS-1:0]     max_col,
  output logic                      plane_done
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned SW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int unsigned SW1   = $clog2(2 * MAX_KERNEL + 1);
  localparam int unsigned KW    = $clog2(MAX_KERNEL + 1);
  localparam int unsigned KX    = (KW > SMALL_BITS) ? KW : SMALL_BITS;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW    = (WW > CFG_DATA_BITS) ? WW : CFG_DATA_BITS;
  localparam int unsigned XW    = EW + 1;
  localparam int unsigned AW    = SW + CW;
  localparam int unsigned DEPTH = MAX_KERNEL << CW;

  // configuration
  logic [3:0]  kernel_width, kernel_height, stride_x, stride_y;
  logic [10:0] image_width, image_height;

  logic [KW-1:0] kwe, khe;
  logic [3:0]    sxe, sye;
  logic [XW-1:0] we, he;

  // plane position
  logic [CW-1:0]       col;
  logic [ROW_BITS-1:0] row;
  logic [2:0]          px, py;
  logic [SW-1:0]       rslot;

  // window scan
  logic [CW-1:0]  cbase, scol;
  logic [SW-1:0]  sslot;
  logic [KW-1:0]  ix, iy, rx, ry, bx, by;
  logic           done_q, rd_v, rd_first;
  logic [SAMPLE_BITS-1:0] rdata, best;

  logic [XW-1:0]  colx, rowx;
  logic           col_ok, row_ok, col_end, row_end, done_c, done_r;
  logic [SW1-1:0] sb_sum, sb_wrap;
  logic [KX-1:0]  kwx, khx;

  assign kwx = KX'(kernel_width);
  assign khx = KX'(kernel_height);

  always_comb begin
    if (kernel_width == '0)                  kwe = KW'(1);
    else if (kwx > KX'(MAX_KERNEL))          kwe = KW'(MAX_KERNEL);
    else                                     kwe = KW'(kwx);
    if (kernel_height == '0)                 khe = KW'(1);
    else if (khx > KX'(MAX_KERNEL))          khe = KW'(MAX_KERNEL);
    else                                     khe = KW'(khx);
    if (stride_x == '0)                      sxe = 4'd1;
    else if (stride_x > 4'(MAX_STRIDE))      sxe = 4'(MAX_STRIDE);
    else                                     sxe = stride_x;
    if (stride_y == '0)                      sye = 4'd1;
    else if (stride_y > 4'(MAX_STRIDE))      sye = 4'(MAX_STRIDE);
    else                                     sye = stride_y;
    if (image_width == '0)                   we = XW'(1);
    else if (XW'(image_width) > XW'(MAX_WIDTH)) we = XW'(MAX_WIDTH);
    else                                     we = XW'(image_width);
    if (image_height == '0)                  he = XW'(1);
    else if (XW'(image_height) > XW'(MAX_HEIGHT)) he = XW'(MAX_HEIGHT);
    else                                     he = XW'(image_height);
  end

  assign colx    = XW'(col);
  assign rowx    = XW'(row);
  assign col_ok  = colx + XW'(1) >= XW'(kwe);
  assign row_ok  = rowx + XW'(1) >= XW'(khe);
  assign col_end = colx + XW'(1) >= we;
  assign row_end = rowx + XW'(1) >= he;
  // last window of the plane: the next origin would not fit
  assign done_c  = colx + XW'(sxe) >= we;
  assign done_r  = rowx + XW'(sye) >= he;

  // first row slot of the window, modulo the line store depth
  assign sb_sum  = SW1'(rslot) + SW1'(MAX_KERNEL) + SW1'(1) - SW1'(khe);
  assign sb_wrap = (sb_sum >= SW1'(MAX_KERNEL)) ? sb_sum - SW1'(MAX_KERNEL) : sb_sum;

  assign status.fire      = col_ok && row_ok && (px == '0) && (py == '0);
  assign status.scan_last = (ix == kwe - KW'(1)) && (iy == khe - KW'(1));
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_width  <= RESET_KERNEL;
      kernel_height <= RESET_KERNEL;
      stride_x      <= RESET_STRIDE;
      stride_y      <= RESET_STRIDE;
      image_width   <= RESET_IMAGE;
      image_height  <= RESET_IMAGE;
      col   <= '0;
      row   <= '0;
      px    <= '0;
      py    <= '0;
      rslot <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INDEX_BITS'(REG_KERNEL_WIDTH):  kernel_width  <= cfg_data[3:0];
        CFG_INDEX_BITS'(REG_KERNEL_HEIGHT): kernel_height <= cfg_data[3:0];
        CFG_INDEX_BITS'(REG_STRIDE_X):      stride_x      <= cfg_data[3:0];
        CFG_INDEX_BITS'(REG_STRIDE_Y):      stride_y      <= cfg_data[3:0];
        CFG_INDEX_BITS'(REG_IMAGE_WIDTH):   image_width   <= cfg_data;
        CFG_INDEX_BITS'(REG_IMAGE_HEIGHT):  image_height  <= cfg_data;
        default: ;
      endcase
      // any write restarts the plane
      col   <= '0;
      row   <= '0;
      px    <= '0;
      py    <= '0;
      rslot <= '0;
    end else if (cmd.write) begin
      if (col_ok) begin
        px <= (XW'(px) + XW'(1) >= XW'(sxe)) ? 3'd0 : px + 3'd1;
      end
      if (col_end) begin
        col <= '0;
        px  <= '0;
        if (row_ok) begin
          py <= (XW'(py) + XW'(1) >= XW'(sye)) ? 3'd0 : py + 3'd1;
        end
        if (row_end) begin
          row   <= '0;
          py    <= '0;
          rslot <= '0;
        end else begin
          row   <= row + ROW_BITS'(1);
          rslot <= (SW1'(rslot) + SW1'(1) >= SW1'(MAX_KERNEL)) ? '0 : rslot + SW'(1);
        end
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // scan address generation
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      cbase  <= CW'(colx + XW'(1) - XW'(kwe));
      scol   <= CW'(colx + XW'(1) - XW'(kwe));
      sslot  <= SW'(sb_wrap);
      ix     <= '0;
      iy     <= '0;
      done_q <= done_c && done_r;
    end else if (cmd.step) begin
      if (ix == kwe - KW'(1)) begin
        ix    <= '0;
        iy    <= iy + KW'(1);
        scol  <= cbase;
        sslot <= (SW1'(sslot) + SW1'(1) >= SW1'(MAX_KERNEL)) ? '0 : sslot + SW'(1);
      end else begin
        ix   <= ix + KW'(1);
        scol <= scol + CW'(1);
      end
    end
  end

  mpa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (cmd.write),
    .wr_addr (AW'({rslot, col})),
    .wr_data (pixel_value),
    .rd_en   (cmd.step),
    .rd_addr (AW'({sslot, scol})),
    .rd_data (rdata)
  );

  // running maximum, strict compare keeps the earliest sample on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= cmd.step;
    end
    rd_first <= cmd.step && (ix == '0) && (iy == '0);
    rx <= ix;
    ry <= iy;
    if (rd_v && (rd_first || ($signed(rdata) > $signed(best)))) begin
      best <= rdata;
      bx   <= rx;
      by   <= ry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load) begin
      max_value  <= best;
      max_row    <= SMALL_BITS'(KX'(by) + KX'(1));
      max_col    <= SMALL_BITS'(KX'(bx) + KX'(1));
      plane_done <= done_q;
    end
  end

endmodule

// File: design/mpa_ctrl.sv
// controller state machine for pixel intake and window scan
module mpa_ctrl import mpa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_PUT
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cmd.write = accept;
  assign cmd.step  = (state == ST_SCAN);
  assign cmd.load  = (state == ST_PUT) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && status.fire) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status.scan_last) begin
            state <= ST_LAST;
          end
        end
        // last read data is compared in this cycle
        ST_LAST: state <= ST_PUT;
        ST_PUT: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_fire_scan: assert property (@(posedge clk) disable iff (rst)
    accept && status.fire |=> state == ST_SCAN)
    else $error("firing pixel did not start a scan");

  a_plain_idle: assert property (@(posedge clk) disable iff (rst)
    accept && !status.fire |=> state == ST_IDLE)
    else $error("non firing pixel left idle");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && status.scan_last |=> state == ST_LAST)
    else $error("scan overran its last read");

  a_last_put: assert property (@(posedge clk) disable iff (rst)
    state == ST_LAST |=> state == ST_PUT && !cmd.step)
    else $error("result stage skipped");

endmodule

// File: design/max_pool_2d_with_argmax.sv
// top level of the 2-d max pooling block with argmax
//
// pixels of one plane enter in raster order on the s_axis channel, planes
// back to back. each pixel is written into a line store of MAX_KERNEL rows.
// when a pixel closes a pooling window the block reads the window back from
// the line store, one sample per cycle, and keeps the running maximum with
// its 1-based row and column. the result leaves on m_axis; tlast marks the
// last window of a plane.
// a pixel that closes no window leaves the block idle and ready. a pixel that
// closes a window stops intake while the single read port of the line store
// reads it back, compares the last read and waits for the output register.
// the output register lets one result wait while the next pixels flow in;
// when the receiver stalls with a result waiting, the block holds the next
// window result and stops taking pixels.
// configuration writes use cfg_write / cfg_index / cfg_data while idle and
// restart the plane counters. reset sets kernel and stride to 2, image to
// 1024 x 1024 and restarts the plane; the line store is not cleared.
module max_pool_2d_with_argmax import mpa_pkg::*; #(
  parameter int unsigned MAX_KERNEL  = 8,
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]         cfg_index,
  input  logic [CFG_DATA_BITS-1:0]          cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pixel_value
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // max_value, max_row, max_col
  output logic [((SAMPLE_BITS+15)/8)*8-1:0] m_axis_tdata,
  output logic                              m_axis_tlast
);

  localparam int unsigned OW = ((SAMPLE_BITS + 15) / 8) * 8;

  cmd_t    cmd;
  status_t status;

  logic [SAMPLE_BITS-1:0] max_value;
  logic [SMALL_BITS-1:0]  max_row, max_col;

  mpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mpa_datapath #(
    .MAX_KERNEL  (MAX_KERNEL),
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_value (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .max_value   (max_value),
    .max_row     (max_row),
    .max_col     (max_col),
    .plane_done  (m_axis_tlast)
  );

  assign m_axis_tdata = OW'({max_col, max_row, max_value});

endmodule

// File: sim/tb_max_pool_2d_with_argmax.sv
// self-checking testbench for the streaming 2-d max pooling block with argmax
`timescale 1ns / 1ps

module tb_max_pool_2d_with_argmax;
  import mpa_pkg::*;

  localparam int STORE_ROWS = 8;
  localparam int STORE_COLS = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int ITEM_BUDGET = 1250;

  class pool_scoreboard;
    logic [3:0] kernel_w, kernel_h, step_x, step_y;
    logic [10:0] img_w, img_h;
    logic signed [15:0] rows [STORE_ROWS*STORE_COLS];
    int col, row, phase_x, phase_y;
    logic [24:0] windows [$];  // last, col, row, value
    int errors;

    function new();
      kernel_w = RESET_KERNEL;
      kernel_h = RESET_KERNEL;
      step_x = RESET_STRIDE;
      step_y = RESET_STRIDE;
      img_w = RESET_IMAGE;
      img_h = RESET_IMAGE;
      foreach (rows[i]) rows[i] = '0;
      restart();
      errors = 0;
    endfunction

    function void restart();
      col = 0;
      row = 0;
      phase_x = 0;
      phase_y = 0;
    endfunction

    function int clampv(int v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function void write_reg(int idx, logic [10:0] v);
      case (idx)
        REG_KERNEL_WIDTH:  kernel_w = v[3:0];
        REG_KERNEL_HEIGHT: kernel_h = v[3:0];
        REG_STRIDE_X:      step_x = v[3:0];
        REG_STRIDE_Y:      step_y = v[3:0];
        REG_IMAGE_WIDTH:   img_w = v;
        REG_IMAGE_HEIGHT:  img_h = v;
        default: ;
      endcase
      restart();
    endfunction

    function void note_pixel(logic signed [15:0] p);
      int kw, kh, sx, sy, w, h, c, r, slot, lc, lr, br, bc;
      logic signed [15:0] best, v;
      kw = clampv(kernel_w, 8);
      kh = clampv(kernel_h, 8);
      sx = clampv(step_x, MAX_STRIDE);
      sy = clampv(step_y, MAX_STRIDE);
      w = clampv(img_w, STORE_COLS);
      h = clampv(img_h, MAX_HEIGHT);
      c = (col >= w) ? w - 1 : col;
      r = (row >= h) ? h - 1 : row;
      rows[(r % STORE_ROWS) * STORE_COLS + c] = p;
      if (c + 1 >= kw && r + 1 >= kh && phase_x == 0 && phase_y == 0) begin
        br = 0;
        bc = 0;
        best = rows[((r + 1 - kh) % STORE_ROWS) * STORE_COLS + c + 1 - kw];
        for (int y = 0; y < kh; y++) begin
          slot = (r + 1 - kh + y) % STORE_ROWS;
          for (int x = 0; x < kw; x++) begin
            v = rows[slot * STORE_COLS + c + 1 - kw + x];
            // strict compare keeps the earliest sample on ties
            if (v > best) begin
              best = v;
              br = y;
              bc = x;
            end
          end
        end
        lc = kw - 1 + ((w - kw) / sx) * sx;
        lr = kh - 1 + ((h - kh) / sy) * sy;
        windows.push_back({(c == lc && r == lr), 4'(bc + 1), 4'(br + 1), best});
      end
      if (c + 1 >= kw) phase_x = (phase_x + 1 >= sx) ? 0 : phase_x + 1;
      if (c + 1 >= w) begin
        col = 0;
        phase_x = 0;
        if (r + 1 >= kh) phase_y = (phase_y + 1 >= sy) ? 0 : phase_y + 1;
        if (r + 1 >= h) begin
          row = 0;
          phase_y = 0;
        end else begin
          row = r + 1;
        end
      end else begin
        col = c + 1;
        row = r;
      end
    endfunction

    function void check_window(logic [23:0] d, logic last);
      logic [24:0] e;
      if (windows.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected window result data=%h last=%b", d, last);
        return;
      end
      e = windows.pop_front();
      if (e[15:0] !== d[15:0] || e[19:16] !== d[19:16] || e[23:20] !== d[23:20] ||
          e[24] !== last) begin
        errors++;
        if (errors <= 10)
          $display({"window mismatch: exp max=%0d row=%0d col=%0d last=%b,",
                    " got max=%0d row=%0d col=%0d last=%b"},
                   $signed(e[15:0]), e[19:16], e[23:20], e[24],
                   $signed(d[15:0]), d[19:16], d[23:20], last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic m_axis_tlast;

  pool_scoreboard sb = new();
  bit quiet = 0;
  bit hold_req = 0;
  int stall_count = 0;
  int sent = 0;

  max_pool_2d_with_argmax dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_window(m_axis_tdata, m_axis_tlast);
  end

  // watchdog on cycles with no request moving in either direction
  always @(posedge clk) begin
    if (rst || cfg_write || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver: random back-pressure bursts, one long hold on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        n = $urandom_range(1, 19);
        repeat (n - 1) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
        n = $urandom_range(1, 30);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic send_pixel(logic [15:0] v);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = v;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic end_stream();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.windows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(int idx, logic [10:0] v);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = CFG_INDEX_BITS'(idx);
    cfg_data = v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // upper data bits of the 4-bit registers are random and must be ignored
  task automatic setup(int kw, int kh, int sx, int sy, int w, int h);
    write_reg(REG_KERNEL_WIDTH, {7'($urandom), 4'(kw)});
    write_reg(REG_KERNEL_HEIGHT, {7'($urandom), 4'(kh)});
    write_reg(REG_STRIDE_X, {7'($urandom), 4'(sx)});
    write_reg(REG_STRIDE_Y, {7'($urandom), 4'(sy)});
    write_reg(REG_IMAGE_WIDTH, 11'(w));
    write_reg(REG_IMAGE_HEIGHT, 11'(h));
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 3)) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] corners [9];
    int kw, kh, sx, sy, w, h, ew, eh, n, phase;
    corners = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001,
                16'h7fff, 16'h8000, 16'h7ffe, 16'h8001};
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // kernel of one: every pixel is its own window, extreme values
    setup(1, 1, 1, 1, 3, 3);
    foreach (corners[i]) send_pixel(corners[i]);
    end_stream();
    wait_idle();
    // all-equal window: first sample wins the tie
    setup(2, 2, 2, 2, 4, 2);
    repeat (8) send_pixel(16'h0005);
    end_stream();
    wait_idle();
    // image smaller than the kernel gives no windows
    setup(8, 8, 1, 1, 3, 2);
    repeat (6) send_pixel(rand_pixel());
    end_stream();
    wait_idle();
    // unknown register index still restarts the plane
    write_reg(6, 11'($urandom));
    write_reg(7, 11'($urandom));

    sent = 0;
    phase = 0;
    while (sent < ITEM_BUDGET) begin
      if (sent > 1000) quiet = 1;
      kw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      kh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      sx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      sy = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      w = $urandom_range(0, 24);
      h = $urandom_range(0, 12);
      case (phase)
        // one full row wider than the line store clamps to its width
        0: begin w = 2047; h = 1; kh = 1; end
        1: begin
          kw = 1; kh = 1; sx = 1; sy = 1; w = 8; h = 8;
          hold_req = 1;  // receiver stalls long enough to back up the input
        end
        default: ;
      endcase
      setup(kw, kh, sx, sy, w, h);
      ew = (w == 0) ? 1 : (w > 1024) ? 1024 : w;
      eh = (h == 0) ? 1 : (h > 1024) ? 1024 : h;
      if (phase == 0) n = ew * eh;
      else n = $urandom_range(1, 2) * ew * eh + $urandom_range(0, ew);
      if (n > ITEM_BUDGET - sent) n = ITEM_BUDGET - sent;
      repeat (n) send_pixel(rand_pixel());
      end_stream();
      wait_idle();
      phase++;
    end

    while (sb.windows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.windows.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
